### hdl/rovq_pkg.sv
`timescale 1ns / 1ps

package rovq_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int MAX_RESULTS     = 64;
    localparam int MATCH_CNT_W     = $clog2(MAX_RESULTS + 1);

    localparam int COORD_W   = 16;
    localparam int ID_W      = 16;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 1;
    localparam int USER_W    = 2;
    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 16;

    localparam logic [CFG_W-1:0] MAX_SIZE_RESET = 10'd128;

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_LOAD  = 2'd1,
        REQ_QUERY = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        ST_LOAD_OK = 2'd0,
        ST_FULL    = 2'd1,
        ST_MATCH   = 2'd2,
        ST_NONE    = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_WIDTH  = 1'b0,
        CFG_MAX_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_SCAN,
        S_FINISH
    } state_t;

    // one table row, 81 bits
    typedef struct packed {
        logic                      live;
        logic [ID_W-1:0]           id;
        logic signed [COORD_W-1:0] bottom;
        logic signed [COORD_W-1:0] right;
        logic signed [COORD_W-1:0] top;
        logic signed [COORD_W-1:0] left;
    } entry_t;

endpackage

### hdl/rovq_table.sv
`timescale 1ns / 1ps

// Box table: one write port, one read port with enable, registered read data.
module rovq_table #(
    parameter int DEPTH = rovq_pkg::TABLE_DEPTH_DEF,
    parameter int AW    = 6
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  rovq_pkg::entry_t wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output rovq_pkg::entry_t rd_data
);
    import rovq_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds while rd_en is low (scan stall)
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/rectangle_overlap_query_table_core.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake          tuser          tdata / tlast
// s_ item   in   s_tvalid/s_tready  [1:0] req_type id,left,top,right,bottom,live
// m_ item   out  m_tvalid/m_tready  [1:0] status   [15:0] match_id, tlast = last
// cfg       in   cfg_we             cfg_index      cfg_wdata (10 bit)
//
// Clear, load and unused codes are handled in idle. A query on N >= 1 entries runs
// set-up, one read per entry, the wait for the last read data and end detection,
// the final result, then the next accept (an empty table skips the reads).
// A new match stalls the scan while one match is held and the output register is
// still full; a result not yet taken on m_ holds off s_tready.
// Reset (aresetn, synchronous, low) empties the table and sets both sizes to 128.
module rectangle_overlap_query_table_core #(
    parameter int TABLE_DEPTH = rovq_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // config write port
    input  logic                                cfg_we,
    input  logic [rovq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rovq_pkg::CFG_W-1:0]          cfg_wdata,
    // input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [15:0] box_id, [31:16] edge_left, [47:32] edge_top, [63:48] edge_right,
    // [79:64] edge_bottom, [80] box_live, [87:81] zero
    input  logic [rovq_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [rovq_pkg::USER_W-1:0]         s_tuser,   // [1:0] req_type
    // result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rovq_pkg::M_TDATA_W-1:0]      m_tdata,   // [15:0] match_id
    output logic [rovq_pkg::USER_W-1:0]         m_tuser,   // [1:0] status
    output logic                                m_tlast
);
    import rovq_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = COORD_W + 1;   // widened span edges

    // ---------------- registers ----------------
    state_t                   state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [CFG_W-1:0]         max_w_reg, max_w_next;
    logic [CFG_W-1:0]         max_h_reg, max_h_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     rd_valid_reg, rd_valid_next;
    logic                     pend_valid_reg, pend_valid_next;

    logic signed [COORD_W-1:0] q_l_reg, q_l_next;
    logic signed [COORD_W-1:0] q_t_reg, q_t_next;
    logic signed [COORD_W-1:0] q_r_reg, q_r_next;
    logic signed [COORD_W-1:0] q_b_reg, q_b_next;
    logic signed [EW-1:0]      xfar_reg, xfar_next;
    logic signed [EW-1:0]      yfar_reg, yfar_next;
    logic [CW-1:0]             idx_reg, idx_next;
    logic [MATCH_CNT_W-1:0]    mcnt_reg, mcnt_next;
    logic [ID_W-1:0]           pend_id_reg, pend_id_next;
    status_t                   out_status_reg, out_status_next;
    logic [ID_W-1:0]           out_id_reg, out_id_next;
    logic                      out_last_reg, out_last_next;

    // ---------------- input decode ----------------
    entry_t in_entry;
    req_t   in_req;
    logic   accept;
    logic   out_free;

    assign in_entry.id     = s_tdata[15:0];
    assign in_entry.left   = s_tdata[31:16];
    assign in_entry.top    = s_tdata[47:32];
    assign in_entry.right  = s_tdata[63:48];
    assign in_entry.bottom = s_tdata[79:64];
    assign in_entry.live   = s_tdata[80];
    assign in_req          = req_t'(s_tuser);

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    // ---------------- table ----------------
    logic   tbl_wr_en;
    logic   tbl_rd_en;
    entry_t rd_entry;

    rovq_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (in_entry),
        .rd_en   (tbl_rd_en),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (rd_entry)
    );

    // ---------------- match test on the row just read ----------------
    logic signed [EW-1:0] ql_x, qt_x, bl_x, br_x, bt_x, bb_x;
    logic inx, iny, hit, stall;

    assign ql_x = EW'(q_l_reg);
    assign qt_x = EW'(q_t_reg);
    assign bl_x = EW'(rd_entry.left);
    assign br_x = EW'(rd_entry.right);
    assign bt_x = EW'(rd_entry.top);
    assign bb_x = EW'(rd_entry.bottom);

    assign inx = (bl_x >= ql_x && bl_x <= xfar_reg) || (br_x >= ql_x && br_x <= xfar_reg);
    assign iny = (bt_x >= qt_x && bt_x <= yfar_reg) || (bb_x >= qt_x && bb_x <= yfar_reg);
    assign hit = inx && (rd_entry.left <= q_r_reg) && iny && (rd_entry.top <= q_b_reg)
                 && rd_entry.live;

    // second match while the held one cannot move to the output register
    assign stall = rd_valid_reg && hit && pend_valid_reg && !out_free;

    // set-up arithmetic for widened spans
    logic signed [EW-1:0] span_x, span_y, mw_x, mh_x;
    assign span_x = EW'(q_r_reg) - EW'(q_l_reg);
    assign span_y = EW'(q_b_reg) - EW'(q_t_reg);
    assign mw_x   = EW'(max_w_reg);
    assign mh_x   = EW'(max_h_reg);

    // ---------------- next state ----------------
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        max_w_next      = max_w_reg;
        max_h_next      = max_h_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        rd_valid_next   = 1'b0;
        pend_valid_next = pend_valid_reg;
        q_l_next        = q_l_reg;
        q_t_next        = q_t_reg;
        q_r_next        = q_r_reg;
        q_b_next        = q_b_reg;
        xfar_next       = xfar_reg;
        yfar_next       = yfar_reg;
        idx_next        = idx_reg;
        mcnt_next       = mcnt_reg;
        pend_id_next    = pend_id_reg;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_last_next   = out_last_reg;
        tbl_wr_en       = 1'b0;
        tbl_rd_en       = 1'b0;

        if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_MAX_WIDTH:  max_w_next = cfg_wdata;
                CFG_MAX_HEIGHT: max_h_next = cfg_wdata;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (in_req)
                        REQ_CLEAR: begin
                            count_next = '0;
                        end
                        REQ_LOAD: begin
                            out_valid_next = 1'b1;
                            out_id_next    = '0;
                            out_last_next  = 1'b1;
                            if (count_reg == CW'(TABLE_DEPTH)) begin
                                out_status_next = ST_FULL;
                            end else begin
                                out_status_next = ST_LOAD_OK;
                                tbl_wr_en       = 1'b1;
                                count_next      = count_reg + 1'b1;
                            end
                        end
                        REQ_QUERY: begin
                            q_l_next   = in_entry.left;
                            q_t_next   = in_entry.top;
                            q_r_next   = in_entry.right;
                            q_b_next   = in_entry.bottom;
                            state_next = S_SETUP;
                        end
                        default: ;   // unused code: no result
                    endcase
                end
            end

            S_SETUP: begin
                xfar_next       = (span_x <= mw_x) ? ql_x + mw_x : EW'(q_r_reg);
                yfar_next       = (span_y <= mh_x) ? qt_x + mh_x : EW'(q_b_reg);
                idx_next        = '0;
                mcnt_next       = '0;
                pend_valid_next = 1'b0;
                state_next      = S_SCAN;
            end

            S_SCAN: begin
                // read side: one row per cycle unless stalled
                if (!stall && idx_reg != count_reg) begin
                    tbl_rd_en     = 1'b1;
                    idx_next      = idx_reg + 1'b1;
                    rd_valid_next = 1'b1;
                end else begin
                    rd_valid_next = stall;
                end

                // evaluate side: newest match is held until the next one shows
                // whether it is the last
                if (rd_valid_reg && hit && !stall) begin
                    mcnt_next       = mcnt_reg + 1'b1;
                    pend_id_next    = rd_entry.id;
                    pend_valid_next = 1'b1;
                    if (pend_valid_reg) begin
                        out_valid_next  = 1'b1;
                        out_status_next = ST_MATCH;
                        out_id_next     = pend_id_reg;
                        out_last_next   = 1'b0;
                    end
                    if (mcnt_reg == MATCH_CNT_W'(MAX_RESULTS - 1)) begin
                        rd_valid_next = 1'b0;
                        state_next    = S_FINISH;
                    end
                end else if (!rd_valid_reg && idx_reg == count_reg) begin
                    state_next = S_FINISH;
                end
            end

            S_FINISH: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_last_next   = 1'b1;
                    out_status_next = pend_valid_reg ? ST_MATCH : ST_NONE;
                    out_id_next     = pend_valid_reg ? pend_id_reg : '0;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            max_w_reg      <= MAX_SIZE_RESET;
            max_h_reg      <= MAX_SIZE_RESET;
            out_valid_reg  <= 1'b0;
            rd_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            max_w_reg      <= max_w_next;
            max_h_reg      <= max_h_next;
            out_valid_reg  <= out_valid_next;
            rd_valid_reg   <= rd_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge aclk) begin
        q_l_reg        <= q_l_next;
        q_t_reg        <= q_t_next;
        q_r_reg        <= q_r_next;
        q_b_reg        <= q_b_next;
        xfar_reg       <= xfar_next;
        yfar_reg       <= yfar_next;
        idx_reg        <= idx_next;
        mcnt_reg       <= mcnt_next;
        pend_id_reg    <= pend_id_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_id_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("table count above depth");

    a_match_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SCAN |-> mcnt_reg < MATCH_CNT_W'(MAX_RESULTS))
        else $error("match count reached limit without ending scan");

    a_idle_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && m_tvalid) |-> m_tlast)
        else $error("non-final result pending while idle");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        stall |=> rd_valid_reg && pend_valid_reg && state_reg == S_SCAN)
        else $error("scan stall lost its held row or match");

endmodule

### tb/rectangle_overlap_query_table_core_tb.sv
`timescale 1ns / 1ps

module rectangle_overlap_query_table_core_tb;

    import rovq_pkg::*;

    localparam int DEPTH      = TABLE_DEPTH_DEF;
    localparam int SETTLE_CYC = 80;     // margin for one full query scan plus output drain
    localparam int STALL_LIM  = 5000;   // idle cycles before the watchdog fires
    localparam int LONG_HOLD  = 400;    // receiver hold-off while the table fills

    // req_type 3 has no name in the package; the block must drop it
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]         req;
        logic [15:0]        id;
        logic signed [15:0] l;
        logic signed [15:0] t;
        logic signed [15:0] r;
        logic signed [15:0] b;
        logic               live;
    } box_item_t;

    typedef struct {
        status_t     st;
        logic [15:0] mid;
        logic        last;
    } hit_t;

    // per offered item: either a hand-typed result or "ask the table model"
    typedef struct {
        bit      typed;
        status_t st;
    } item_tag_t;

    typedef struct {
        box_item_t it;
        item_tag_t tag;
    } dir_row_t;

    // ------------------------------------------------------------------
    // DUT signals; every input has a known value from time 0
    // ------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_MAX_WIDTH;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // [15:0] id, [31:16] left, [47:32] top,
                                             // [63:48] right, [79:64] bottom, [80] live
    logic [USER_W-1:0]     s_tuser   = '0;   // [1:0] req_type
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;          // [15:0] match_id
    logic [USER_W-1:0]     m_tuser;          // [1:0] status
    logic                  m_tlast;

    rectangle_overlap_query_table_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Box table model: own copy of the sizes and the table
    // ------------------------------------------------------------------
    int          size_w = 128;
    int          size_h = 128;
    int          tbl_count = 0;
    int          tbl_l [DEPTH];
    int          tbl_t [DEPTH];
    int          tbl_r [DEPTH];
    int          tbl_b [DEPTH];
    logic [15:0] tbl_id [DEPTH];
    logic        tbl_live [DEPTH];

    hit_t        model_out [$];    // results of the item just applied
    hit_t        due_hits [$];     // results still to come off the m_ side
    item_tag_t   tag_q [$];        // one per offered item, in offer order

    // bookkeeping
    int err_cnt   = 0;
    int idle_cyc  = 0;
    int n_items   = 0;
    int n_loads   = 0;
    int n_queries = 0;
    int n_clears  = 0;
    int n_unused  = 0;
    int n_matches = 0;
    int n_full    = 0;
    int n_nohit   = 0;
    int n_sizes   = 1;

    bit tx_idle_on = 1'b0;
    bit rx_idle_on = 1'b0;
    int rx_hold    = 0;

    function automatic void apply_item(input logic [1:0] req, input logic [S_TDATA_W-1:0] d);
        logic signed [15:0] el, et, er, eb;
        int   l, t, r, b, xfar, yfar, n;
        bit   inx, iny;
        el = d[31:16];
        et = d[47:32];
        er = d[63:48];
        eb = d[79:64];
        l = int'(el);
        t = int'(et);
        r = int'(er);
        b = int'(eb);
        model_out.delete();
        case (req)
            REQ_CLEAR: begin
                tbl_count = 0;
            end
            REQ_LOAD: begin
                if (tbl_count >= DEPTH) begin
                    model_out.push_back('{ST_FULL, 16'd0, 1'b1});
                end else begin
                    tbl_l[tbl_count]    = l;
                    tbl_t[tbl_count]    = t;
                    tbl_r[tbl_count]    = r;
                    tbl_b[tbl_count]    = b;
                    tbl_id[tbl_count]   = d[15:0];
                    tbl_live[tbl_count] = d[80];
                    tbl_count++;
                    model_out.push_back('{ST_LOAD_OK, 16'd0, 1'b1});
                end
            end
            REQ_QUERY: begin
                // narrow/short spans get their far edge pushed out
                xfar = r;
                yfar = b;
                if (r - l <= size_w) xfar = l + size_w;
                if (b - t <= size_h) yfar = t + size_h;
                n = 0;
                for (int i = 0; i < tbl_count && n < MAX_RESULTS; i++) begin
                    inx = (tbl_l[i] >= l && tbl_l[i] <= xfar) ||
                          (tbl_r[i] >= l && tbl_r[i] <= xfar);
                    iny = (tbl_t[i] >= t && tbl_t[i] <= yfar) ||
                          (tbl_b[i] >= t && tbl_b[i] <= yfar);
                    if (inx && tbl_l[i] <= r && iny && tbl_t[i] <= b && tbl_live[i]) begin
                        model_out.push_back('{ST_MATCH, tbl_id[i], 1'b0});
                        n++;
                    end
                end
                if (n == 0) model_out.push_back('{ST_NONE, 16'd0, 1'b1});
                else model_out[n-1].last = 1'b1;
            end
            default: begin
                // unused code: no result, table untouched
            end
        endcase
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        err_cnt++;
    endtask

    // ------------------------------------------------------------------
    // Bus monitor: both sides sampled at the rising edge, input side first
    // so a result can never be checked before its item is modelled.
    // Also feeds the watchdog.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        hit_t      h;
        item_tag_t tg;
        if (aresetn && s_tvalid && s_tready) begin
            apply_item(s_tuser, s_tdata);
            n_items++;
            case (s_tuser)
                REQ_CLEAR: n_clears++;
                REQ_LOAD:  n_loads++;
                REQ_QUERY: n_queries++;
                default:   n_unused++;
            endcase
            if (tag_q.size() == 0) begin
                flag_mismatch("item accepted that was never offered");
            end else begin
                tg = tag_q.pop_front();
                if (tg.typed) begin
                    due_hits.push_back('{tg.st, 16'd0, 1'b1});
                end else begin
                    foreach (model_out[k]) due_hits.push_back(model_out[k]);
                end
            end
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (due_hits.size() == 0) begin
                flag_mismatch($sformatf("unexpected result status=%0d id=%h last=%b",
                                        m_tuser, m_tdata, m_tlast));
            end else begin
                h = due_hits.pop_front();
                if (m_tuser !== h.st)
                    flag_mismatch($sformatf("status %0d, want %0d", m_tuser, h.st));
                if (m_tdata !== h.mid)
                    flag_mismatch($sformatf("match_id %h, want %h", m_tdata, h.mid));
                if (m_tlast !== h.last)
                    flag_mismatch($sformatf("last %b, want %b", m_tlast, h.last));
                case (h.st)
                    ST_MATCH: n_matches++;
                    ST_FULL:  n_full++;
                    ST_NONE:  n_nohit++;
                    default:  ;
                endcase
            end
        end

        // watchdog: cycles with no handshake on either side, no config write and no reset
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !aresetn)
            idle_cyc = 0;
        else
            idle_cyc++;
        if (idle_cyc >= STALL_LIM) begin
            $display("[%0t] watchdog: no handshake for %0d cycles, %0d results pending",
                     $time, idle_cyc, due_hits.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result sink: random back-pressure per item, or one long hold-off
    // when the stimulus asks for it
    // ------------------------------------------------------------------
    initial begin : result_sink
        int wait_n;
        while (!aresetn) @(negedge aclk);
        forever begin
            if (rx_hold > 0) begin
                wait_n  = rx_hold;
                rx_hold = 0;
            end else begin
                wait_n = rx_idle_on ? $urandom_range(0, 11) : 0;
            end
            if (wait_n > 0) begin
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (wait_n - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // offer one item after a random gap (when sender idling is on), return at the accepting edge
    task automatic offer_item(input box_item_t it, input item_tag_t tg);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        tag_q.push_back(tg);
        s_tvalid <= 1'b1;
        s_tuser  <= it.req;
        s_tdata  <= {7'd0, it.live, it.b, it.r, it.t, it.l, it.id};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic offer_modelled(input box_item_t it);
        offer_item(it, '{1'b0, ST_NONE});
    endtask

    // stop offering, wait for every pending result, then let the scan finish
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (due_hits.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    // both size registers, back to back; only called when the block is idle
    task automatic set_sizes(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAX_WIDTH;
        cfg_wdata <= w;
        @(negedge aclk);
        cfg_index <= CFG_MAX_HEIGHT;
        cfg_wdata <= h;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        size_w = int'(w);
        size_h = int'(h);
        n_sizes++;
    endtask

    function automatic int clamp16(input int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic dir_row_t mk_row(input logic [1:0] req, input int id,
                                        input int l, input int t, input int r, input int b,
                                        input bit live, input bit typed, input status_t st);
        dir_row_t row;
        row.it  = '{req, id[15:0], l[15:0], t[15:0], r[15:0], b[15:0], live};
        row.tag = '{typed, st};
        return row;
    endfunction

    // mostly boxes and searches clustered around a center so queries hit,
    // sometimes fully random edges, sometimes reversed edges
    function automatic box_item_t rand_item(input int center);
        box_item_t it;
        int k, l, t, r, b, span, tmp;
        k = $urandom_range(0, 99);
        if (k < 4)       it.req = REQ_CLEAR;
        else if (k < 6)  it.req = REQ_UNUSED;
        else if (k < 50) it.req = REQ_LOAD;
        else             it.req = REQ_QUERY;
        it.id   = 16'($urandom);
        it.live = ($urandom_range(0, 7) != 0);
        if ($urandom_range(0, 6) == 0) begin
            it.l = 16'($urandom);
            it.t = 16'($urandom);
            it.r = 16'($urandom);
            it.b = 16'($urandom);
        end else begin
            span = (it.req == REQ_LOAD) ? 200 : 600;
            l = clamp16(center + $urandom_range(0, 600) - 300);
            t = clamp16(center + $urandom_range(0, 600) - 300);
            r = clamp16(l + $urandom_range(0, span));
            b = clamp16(t + $urandom_range(0, span));
            if ($urandom_range(0, 9) == 0) begin
                tmp = l; l = r; r = tmp;
            end
            if ($urandom_range(0, 9) == 0) begin
                tmp = t; t = b; b = tmp;
            end
            it.l = l[15:0];
            it.t = t[15:0];
            it.r = r[15:0];
            it.b = b[15:0];
        end
        return it;
    endfunction

    // random run; idling re-drawn every stretch of 25 items
    task automatic run_random(input int count, input bit tx_mode, input bit rx_mode);
        int center;
        center = 0;
        for (int k = 0; k < count; k++) begin
            if (k % 25 == 0) begin
                tx_idle_on = tx_mode && ($urandom_range(0, 2) != 0);
                rx_idle_on = rx_mode && ($urandom_range(0, 2) != 0);
                case ($urandom_range(0, 3))
                    0:       center = 0;
                    1:       center = -32500;
                    2:       center = 32500;
                    default: center = $urandom_range(0, 60000) - 30000;
                endcase
            end
            offer_modelled(rand_item(center));
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        dir_row_t  dir_rows [$];
        box_item_t it;

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // directed rows at the reset sizes (128 x 128)
        dir_rows.push_back(mk_row(REQ_QUERY, 0, 0, 0, 0, 0, 0, 1, ST_NONE));   // empty table
        dir_rows.push_back(mk_row(REQ_LOAD, 16'hFFFF, -32768, -32768, 32767, 32767, 1,
                                  1, ST_LOAD_OK));
        dir_rows.push_back(mk_row(REQ_LOAD, 0, 32767, 32767, -32768, -32768, 1,
                                  1, ST_LOAD_OK));                              // reversed
        dir_rows.push_back(mk_row(REQ_LOAD, 16'h1234, 10, 10, 20, 20, 0, 1, ST_LOAD_OK));
        dir_rows.push_back(mk_row(REQ_LOAD, 16'hA5A5, 0, 0, 50, 50, 1, 1, ST_LOAD_OK));
        dir_rows.push_back(mk_row(REQ_QUERY, 0, 0, 0, 100, 100, 0, 0, ST_NONE));
        dir_rows.push_back(mk_row(REQ_QUERY, 0, -32768, -32768, 32767, 32767, 0, 0, ST_NONE));
        dir_rows.push_back(mk_row(REQ_QUERY, 0, 32767, 32767, 32767, 32767, 0, 0, ST_NONE));
        dir_rows.push_back(mk_row(REQ_QUERY, 0, 100, 100, -100, -100, 0, 0, ST_NONE));
        dir_rows.push_back(mk_row(REQ_UNUSED, 16'hFFFF, -1, -1, -1, -1, 1, 0, ST_NONE));
        dir_rows.push_back(mk_row(REQ_QUERY, 0, 15, 15, 15, 15, 0, 0, ST_NONE)); // dead box
        dir_rows.push_back(mk_row(REQ_QUERY, 0, -32768, -32768, -32768, -32768, 0,
                                  0, ST_NONE));
        dir_rows.push_back(mk_row(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, ST_NONE));
        dir_rows.push_back(mk_row(REQ_QUERY, 0, -32768, -32768, 32767, 32767, 0,
                                  1, ST_NONE));                                 // after clear
        dir_rows.push_back(mk_row(REQ_LOAD, 16'h5A5A, 21845, -21846, -21846, 21845, 1,
                                  1, ST_LOAD_OK));
        dir_rows.push_back(mk_row(REQ_QUERY, 0, 21845, -21846, 21845, -21846, 0, 0, ST_NONE));
        dir_rows.push_back(mk_row(REQ_QUERY, 0, -32768, -21846, 32767, 0, 0, 0, ST_NONE));

        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        foreach (dir_rows[k]) offer_item(dir_rows[k].it, dir_rows[k].tag);
        settle();

        // smallest sizes: no widening beyond the near edge
        set_sizes(10'd0, 10'd0);
        run_random(50, 1'b1, 1'b1);
        settle();

        // largest sizes
        set_sizes(10'd1023, 10'd1023);
        run_random(50, 1'b1, 1'b0);
        settle();

        // Fill the table while the receiver holds off: the load results back
        // up and the block has to stall its input. Loads past the table depth
        // must report full. Then one query that hits every entry.
        set_sizes(10'd5, 10'd700);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        offer_modelled('{REQ_CLEAR, 16'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0});
        rx_hold = LONG_HOLD;
        for (int k = 0; k < DEPTH + 6; k++) begin
            it.req  = REQ_LOAD;
            it.id   = 16'($urandom);
            it.l    = 16'($urandom_range(0, 100));
            it.t    = 16'($urandom_range(0, 100));
            it.r    = it.l + 16'($urandom_range(0, 50));
            it.b    = it.t + 16'($urandom_range(0, 50));
            it.live = 1'b1;
            offer_modelled(it);
        end
        offer_modelled('{REQ_QUERY, 16'd0, -16'sd1000, -16'sd1000, 16'sd1000, 16'sd1000, 1'b0});
        // sender waits here until the full match list has drained
        settle();

        set_sizes(10'd1023, 10'd0);
        run_random(50, 1'b0, 1'b0);
        settle();

        set_sizes(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
        run_random(50, 1'b0, 1'b1);
        settle();

        set_sizes(10'd128, 10'd128);
        run_random(50, 1'b1, 1'b1);
        settle();

        $display("covered %0d items: %0d loads, %0d queries, %0d clears, %0d unused codes,",
                 n_items, n_loads, n_queries, n_clears, n_unused);
        $display("  %0d size settings; results checked: %0d match ids, %0d table-full, %0d no-match",
                 n_sizes, n_matches, n_full, n_nohit);
        if (err_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### sim.f
hdl/rovq_pkg.sv
hdl/rovq_table.sv
hdl/rectangle_overlap_query_table_core.sv
tb/rectangle_overlap_query_table_core_tb.sv
